// ----- design/i2c_master_line_sequencer_top_assert.svh -----
// Assertion macros for the I2C master line sequencer.
// Each macro is clocked on clk and held off while rst_n is low.
`ifndef I2C_MASTER_LINE_SEQUENCER_TOP_ASSERT_SVH
`define I2C_MASTER_LINE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication.
`define I2CMLS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CMLS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/i2cmls_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cmls_pkg
// Shared types and constants for the I2C master line sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmls_pkg;

  typedef enum logic [2:0] {
    KIND_START     = 3'd0,
    KIND_STOP      = 3'd1,
    KIND_SEND_BYTE = 3'd2,
    KIND_RECV_BYTE = 3'd3,
    KIND_SEND_ACK  = 3'd4,
    KIND_RECV_ACK  = 3'd5,
    KIND_SAMPLE    = 3'd6,
    KIND_NONE      = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    RM_IDLE = 2'd0,
    RM_BYTE = 2'd1,
    RM_ACK  = 2'd2
  } read_mode_t;

  // step phases within one bit slot
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;

  localparam logic [15:0] HOLD_RESET = 16'd500;
  localparam logic [2:0]  LAST_BIT   = 3'd7;
  localparam logic [3:0]  BYTE_BITS  = 4'd8;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       req;
    logic       rvalid;
    logic [7:0] rvalue;
    logic       err;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ----- design/i2c_master_line_sequencer_top.sv -----
// First line change of an accepted command: command register, then output register.
// Throughput: one line change per cycle unless out_ready stalls; a command makes
//   0 to 24 changes (send byte 24, start 4, stop 3, send ack 3, reads 2, samples 1
//   or 2, rejected transactions 1, kind 7 none), set by the single step sequencer.
// The next command is taken in the cycle its predecessor's last change is produced.
// Reset (rst_n low, synchronous): SCL/SDA released high, no read pending, hold 500.
// ----------------------------------------------------------------------------
// i2c_master_line_sequencer_top
// Byte level I2C master: turns commands and SDA samples into SCL/SDA level changes.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_line_sequencer_top
  import i2cmls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command / sample channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_ack_bit,
  input  wire logic        in_sda_sample,
  // line change channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_scl_level,
  output logic             out_sda_level,
  output logic             out_sample_request,
  output logic             out_read_valid,
  output logic [7:0]       out_read_value,
  output logic             out_misuse_error,
  output logic             out_last_of_run,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  // Hold time per level. Kept for the bus timer; results never depend on it.
  logic [15:0] hold_cycles_r;

  // Command register: the transaction being sequenced.
  logic        busy_r, busy_nxt;
  kind_t       kind_r;
  logic [7:0]  data_r;
  logic        ack_r;
  logic        smp_r;
  // Step position: bit slot (send byte only) and phase within the slot.
  logic [2:0]  bit_r, bit_nxt;
  logic [1:0]  phase_r, phase_nxt;

  // Line and read state.
  read_mode_t  read_mode_r, read_mode_nxt;
  logic [3:0]  bit_count_r, bit_count_nxt;
  logic [7:0]  shift_byte_r, shift_byte_nxt;
  logic        scl_now_r, scl_now_nxt;
  logic        sda_now_r, sda_now_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;

  res_t        gen;
  logic        adv;
  logic        accept;
  logic        misuse;
  logic [3:0]  cnt_inc;
  logic [7:0]  shift_inc;

  // Produce a change when a command is loaded and the output slot frees up.
  assign adv      = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (adv && gen.last);
  assign accept   = in_valid && in_ready;

  assign cnt_inc   = bit_count_r + 4'd1;
  assign shift_inc = {shift_byte_r[6:0], smp_r};
  // A sample with no read pending, or a command during a read, is rejected.
  assign misuse    = (kind_r == KIND_SAMPLE) != (read_mode_r != RM_IDLE);

  always_comb begin
    logic scl_n;
    logic sda_n;
    scl_n          = scl_now_r;
    sda_n          = sda_now_r;
    gen            = '0;
    read_mode_nxt  = read_mode_r;
    bit_count_nxt  = bit_count_r;
    shift_byte_nxt = shift_byte_r;

    if (misuse) begin
      gen.err  = 1'b1;
      gen.last = 1'b1;
    end else begin
      unique case (kind_r)
        KIND_START: begin
          unique case (phase_r)
            PH_0:    sda_n = 1'b1;
            PH_1:    scl_n = 1'b1;
            PH_2:    sda_n = 1'b0;
            default: begin
              scl_n    = 1'b0;
              gen.last = 1'b1;
            end
          endcase
        end
        KIND_STOP: begin
          unique case (phase_r)
            PH_0:    sda_n = 1'b0;
            PH_1:    scl_n = 1'b1;
            default: begin
              sda_n    = 1'b1;
              gen.last = 1'b1;
            end
          endcase
        end
        KIND_SEND_BYTE, KIND_SEND_ACK: begin
          unique case (phase_r)
            PH_0:    sda_n = (kind_r == KIND_SEND_BYTE) ? data_r[LAST_BIT - bit_r] : ack_r;
            PH_1:    scl_n = 1'b1;
            default: begin
              scl_n    = 1'b0;
              gen.last = (kind_r == KIND_SEND_ACK) || (bit_r == LAST_BIT);
            end
          endcase
        end
        KIND_RECV_BYTE, KIND_RECV_ACK: begin
          if (phase_r == PH_0) begin
            sda_n = 1'b1;
          end else begin
            // Read mode opens on the last change so the misuse check stays stable.
            scl_n          = 1'b1;
            gen.req        = 1'b1;
            gen.last       = 1'b1;
            read_mode_nxt  = (kind_r == KIND_RECV_BYTE) ? RM_BYTE : RM_ACK;
            bit_count_nxt  = 4'd0;
            shift_byte_nxt = 8'd0;
          end
        end
        KIND_SAMPLE: begin
          if (read_mode_r == RM_BYTE) begin
            if (phase_r == PH_0) begin
              shift_byte_nxt = shift_inc;
              if (cnt_inc >= BYTE_BITS) begin
                scl_n         = 1'b0;
                gen.rvalid    = 1'b1;
                gen.rvalue    = shift_inc;
                gen.last      = 1'b1;
                read_mode_nxt = RM_IDLE;
                bit_count_nxt = 4'd0;
              end else begin
                scl_n         = 1'b0;
                bit_count_nxt = cnt_inc;
              end
            end else begin
              scl_n    = 1'b1;
              gen.req  = 1'b1;
              gen.last = 1'b1;
            end
          end else begin
            scl_n         = 1'b0;
            gen.rvalid    = 1'b1;
            gen.rvalue    = {7'd0, smp_r};
            gen.last      = 1'b1;
            read_mode_nxt = RM_IDLE;
          end
        end
        default: begin
          gen.last = 1'b1;
        end
      endcase
    end

    gen.scl = scl_n;
    gen.sda = sda_n;

    // Commit state only when the change is actually produced.
    scl_now_nxt = adv ? scl_n : scl_now_r;
    sda_now_nxt = adv ? sda_n : sda_now_r;
    if (!adv) begin
      read_mode_nxt  = read_mode_r;
      bit_count_nxt  = bit_count_r;
      shift_byte_nxt = shift_byte_r;
    end
  end

  // Step counter and command occupancy.
  always_comb begin
    bit_nxt   = bit_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    if (adv) begin
      if (gen.last) begin
        bit_nxt   = 3'd0;
        phase_nxt = PH_0;
        busy_nxt  = 1'b0;
      end else if (kind_r == KIND_SEND_BYTE && phase_r == PH_2) begin
        bit_nxt   = bit_r + 3'd1;
        phase_nxt = PH_0;
      end else begin
        phase_nxt = phase_r + 2'd1;
      end
    end
    // kind 7 is swallowed: accepted, no changes.
    if (accept && kind_t'(in_kind) != KIND_NONE) begin
      busy_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles_r <= HOLD_RESET;
      busy_r        <= 1'b0;
      bit_r         <= 3'd0;
      phase_r       <= PH_0;
      read_mode_r   <= RM_IDLE;
      bit_count_r   <= 4'd0;
      shift_byte_r  <= 8'd0;
      scl_now_r     <= 1'b1;
      sda_now_r     <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hold_cycles_r <= cfg_wr_data;
      end
      busy_r       <= busy_nxt;
      bit_r        <= bit_nxt;
      phase_r      <= phase_nxt;
      read_mode_r  <= read_mode_nxt;
      bit_count_r  <= bit_count_nxt;
      shift_byte_r <= shift_byte_nxt;
      scl_now_r    <= scl_now_nxt;
      sda_now_r    <= sda_now_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      data_r <= in_data_byte;
      ack_r  <= in_ack_bit;
      smp_r  <= in_sda_sample;
    end
    if (adv) begin
      out_res_r <= gen;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_scl_level      = out_res_r.scl;
  assign out_sda_level      = out_res_r.sda;
  assign out_sample_request = out_res_r.req;
  assign out_read_valid     = out_res_r.rvalid;
  assign out_read_value     = out_res_r.rvalue;
  assign out_misuse_error   = out_res_r.err;
  assign out_last_of_run    = out_res_r.last;

`include "i2c_master_line_sequencer_top_assert.svh"

  // A rejected transaction yields exactly one change.
  `I2CMLS_ASSERT_NOW(a_misuse_last, out_valid && out_misuse_error, out_last_of_run, "misuse not last")
  // A completed read always ends with SCL low on the final change.
  `I2CMLS_ASSERT_NOW(a_read_done, out_valid && out_read_valid, !out_scl_level && out_last_of_run, "read end bad")
  // A new command only overlaps the old one on its final change.
  `I2CMLS_ASSERT_NOW(a_handoff, busy_r && in_ready, adv && gen.last, "early handoff")
  // A produced change lands in the output register.
  `I2CMLS_ASSERT_NEXT(a_out_load, adv, out_valid && out_res_r == $past(gen), "change lost")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: I2C master line sequencer testbench
// Drives commands and SDA samples into the sequencer. A cycle-free predictor
// tracks the bus state and queues the expected SCL/SDA changes. Every change
// the block emits is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmls_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_STALL   = 400;

  // Predicts line changes per accepted command and checks emitted changes.
  class line_change_board;
    read_mode_t  rd_mode;
    logic [3:0]  bits_in;
    logic [7:0]  rx_shift;
    logic        scl_now;
    logic        sda_now;
    logic [15:0] hold_cycles;
    res_t        expected_changes[$];
    res_t        run_buf[$];
    int          fail_count;
    int          changes_checked;
    int          reads_done;
    int          misuse_seen;

    function new();
      rd_mode     = RM_IDLE;
      bits_in     = '0;
      rx_shift    = '0;
      scl_now     = 1'b1;
      sda_now     = 1'b1;
      hold_cycles = HOLD_RESET;
    endfunction

    function void push_change(logic req, logic rvalid, logic [7:0] rvalue, logic err);
      res_t r;
      r.scl    = scl_now;
      r.sda    = sda_now;
      r.req    = req;
      r.rvalid = rvalid;
      r.rvalue = rvalue;
      r.err    = err;
      r.last   = 1'b0;
      run_buf.push_back(r);
    endfunction

    function void drive_sda(logic v);
      sda_now = v;
      push_change(1'b0, 1'b0, 8'h00, 1'b0);
    endfunction

    function void drive_scl(logic v, logic req);
      scl_now = v;
      push_change(req, 1'b0, 8'h00, 1'b0);
    endfunction

    // Work out the changes caused by one accepted transaction.
    function void predict_changes(kind_t k, logic [7:0] data, logic ack, logic smp);
      res_t r;
      run_buf.delete();
      if (k == KIND_NONE) return;
      if ((k == KIND_SAMPLE) != (rd_mode != RM_IDLE)) begin
        // wrong read phase: ignored, levels unchanged
        push_change(1'b0, 1'b0, 8'h00, 1'b1);
      end else begin
        case (k)
          KIND_START: begin
            drive_sda(1'b1);
            drive_scl(1'b1, 1'b0);
            drive_sda(1'b0);
            drive_scl(1'b0, 1'b0);
          end
          KIND_STOP: begin
            drive_sda(1'b0);
            drive_scl(1'b1, 1'b0);
            drive_sda(1'b1);
          end
          KIND_SEND_BYTE: begin
            for (int i = 7; i >= 0; i--) begin
              drive_sda(data[i]);
              drive_scl(1'b1, 1'b0);
              drive_scl(1'b0, 1'b0);
            end
          end
          KIND_RECV_BYTE, KIND_RECV_ACK: begin
            rd_mode  = (k == KIND_RECV_BYTE) ? RM_BYTE : RM_ACK;
            bits_in  = '0;
            rx_shift = '0;
            drive_sda(1'b1);
            drive_scl(1'b1, 1'b1);
          end
          KIND_SEND_ACK: begin
            drive_sda(ack);
            drive_scl(1'b1, 1'b0);
            drive_scl(1'b0, 1'b0);
          end
          default: begin
            if (rd_mode == RM_BYTE) begin
              rx_shift = {rx_shift[6:0], smp};
              bits_in  = bits_in + 4'd1;
              if (bits_in >= BYTE_BITS) begin
                scl_now = 1'b0;
                push_change(1'b0, 1'b1, rx_shift, 1'b0);
                rd_mode = RM_IDLE;
                bits_in = '0;
              end else begin
                drive_scl(1'b0, 1'b0);
                drive_scl(1'b1, 1'b1);
              end
            end else begin
              scl_now = 1'b0;
              push_change(1'b0, 1'b1, {7'b0, smp}, 1'b0);
              rd_mode = RM_IDLE;
            end
          end
        endcase
      end
      r = run_buf.pop_back();
      r.last = 1'b1;
      run_buf.push_back(r);
      foreach (run_buf[i]) expected_changes.push_back(run_buf[i]);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0h, got %0h", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_change(res_t got);
      res_t want;
      changes_checked++;
      if (got.rvalid === 1'b1) reads_done++;
      if (got.err === 1'b1) misuse_seen++;
      if (expected_changes.size() == 0) begin
        $error("line change with nothing expected: scl %0b sda %0b", got.scl, got.sda);
        fail_count++;
        return;
      end
      want = expected_changes.pop_front();
      compare_field("scl_level", want.scl, got.scl);
      compare_field("sda_level", want.sda, got.sda);
      compare_field("sample_request", want.req, got.req);
      compare_field("read_valid", want.rvalid, got.rvalid);
      compare_field("read_value", want.rvalue, got.rvalue);
      compare_field("misuse_error", want.err, got.err);
      compare_field("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [7:0]  in_data_byte;
  logic        in_ack_bit;
  logic        in_sda_sample;
  logic        out_valid;
  logic        out_ready;
  logic        out_scl_level;
  logic        out_sda_level;
  logic        out_sample_request;
  logic        out_read_valid;
  logic [7:0]  out_read_value;
  logic        out_misuse_error;
  logic        out_last_of_run;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  line_change_board board;

  // steady: neither side idles; hold_off_req: asks the receiver for a long stall
  bit steady;
  int hold_off_req;
  int items_sent;

  i2c_master_line_sequencer_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_data_byte      (in_data_byte),
    .in_ack_bit        (in_ack_bit),
    .in_sda_sample     (in_sda_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_scl_level     (out_scl_level),
    .out_sda_level     (out_sda_level),
    .out_sample_request(out_sample_request),
    .out_read_valid    (out_read_valid),
    .out_read_value    (out_read_value),
    .out_misuse_error  (out_misuse_error),
    .out_last_of_run   (out_last_of_run),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: the run must be over well before this.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  // Result side. Random back-pressure, or a long stall when the sender asks
  // for one. The stall is counted here so the sender keeps offering commands
  // and the block backs up into its input.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req > 0) begin
        stall_left   = hold_off_req;
        hold_off_req = 0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 29);
      end
    end
  end

  // Monitor: every result transaction goes to the board, pre-edge values.
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_scl_level, out_sda_level, out_sample_request, out_read_valid,
             out_read_value, out_misuse_error, out_last_of_run};
      board.check_change(got);
    end
  end

  // One input transaction. Optional random idle cycles first, then valid is
  // held with a stable payload until the edge where ready is seen.
  task automatic offer(kind_t k, logic [7:0] data, logic ack, logic smp);
    if (!steady) begin
      while ($urandom_range(0, 99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid      <= 1'b1;
    in_kind       <= k;
    in_data_byte  <= data;
    in_ack_bit    <= ack;
    in_sda_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.predict_changes(k, data, ack, smp);
    if (k != KIND_NONE) items_sent++;
  endtask

  // Unused payload fields get random values so every input bit toggles.
  task automatic cmd(kind_t k);
    offer(k, 8'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic sample(logic smp);
    offer(KIND_SAMPLE, 8'($urandom), 1'($urandom), smp);
  endtask

  // Byte read; now and then a command lands in the middle of it.
  task automatic read_byte(bit with_misuse);
    int poke_at;
    poke_at = $urandom_range(0, 7);
    cmd(KIND_RECV_BYTE);
    for (int i = 0; i < 8; i++) begin
      if (with_misuse && i == poke_at) cmd(kind_t'($urandom_range(0, 5)));
      sample(1'($urandom));
    end
  endtask

  // Stop offering and wait until every expected change has come out, plus
  // a margin for items that cause no change.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_changes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_hold(logic [15:0] cycles);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cycles;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    board.hold_cycles = cycles;
  endtask

  // Mostly well-formed bus transfers (start, byte writes with ack reads,
  // byte reads with ack sends, stop) with random content; the rest is noise.
  task automatic random_traffic(int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        cmd(KIND_START);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 1) == 0) begin
            offer(KIND_SEND_BYTE, 8'($urandom), 1'($urandom), 1'($urandom));
            cmd(KIND_RECV_ACK);
            sample(1'($urandom));
          end else begin
            read_byte($urandom_range(0, 9) == 0);
            cmd(KIND_SEND_ACK);
          end
        end
        cmd(KIND_STOP);
      end else begin
        case ($urandom_range(0, 3))
          0: sample(1'($urandom));                      // stray sample
          1: offer(kind_t'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                   1'($urandom));                        // any item at all
          2: cmd(KIND_NONE);
          default: begin                                 // command during ack read
            cmd(KIND_RECV_ACK);
            cmd(kind_t'($urandom_range(0, 5)));
          end
        endcase
        // close any read the noise left open
        while (board.rd_mode != RM_IDLE) sample(1'($urandom));
      end
    end
  endtask

  initial begin
    int base;
    logic [7:0] rx_pattern;
    board = new();
    steady       = 1'b0;
    hold_off_req = 0;
    items_sent   = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_kind       <= KIND_NONE;
    in_data_byte  <= 8'h00;
    in_ack_bit    <= 1'b0;
    in_sda_sample <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= 16'h0000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset hold value: every command, byte extremes,
    // both ack levels, a full byte read, and the ignored cases.
    cmd(KIND_START);
    offer(KIND_SEND_BYTE, 8'h00, 1'b0, 1'b0);
    offer(KIND_SEND_BYTE, 8'hFF, 1'b1, 1'b1);
    offer(KIND_SEND_BYTE, 8'hA5, 1'b0, 1'b1);
    cmd(KIND_RECV_ACK);
    sample(1'b0);
    cmd(KIND_RECV_BYTE);
    rx_pattern = 8'b1011_0010;
    for (int i = 7; i >= 0; i--) sample(rx_pattern[i]);
    offer(KIND_SEND_ACK, 8'hFF, 1'b0, 1'b1);
    offer(KIND_SEND_ACK, 8'h00, 1'b1, 1'b0);
    sample(1'b1);                  // stray sample, no read pending
    cmd(KIND_RECV_ACK);
    cmd(KIND_START);               // command while the ack read is pending
    sample(1'b1);
    cmd(KIND_NONE);                // no-op kind: no change at all
    cmd(KIND_STOP);
    wait_idle();

    // Hold extremes: pacing only, results must not move.
    write_hold(16'hFFFF);
    cmd(KIND_START);
    cmd(KIND_STOP);
    wait_idle();
    write_hold(16'h0000);
    cmd(KIND_START);
    cmd(KIND_STOP);
    wait_idle();

    // Random part in phases, each with its own hold value.
    base = items_sent;
    write_hold(16'd1);
    random_traffic(base + 100);
    wait_idle();

    // Long stretch with no idling on either side.
    write_hold(16'($urandom_range(2, 40)));
    steady = 1'b1;
    random_traffic(base + 200);
    steady = 1'b0;
    wait_idle();

    // Receiver stalls for a long stretch while commands keep coming, so the
    // block fills up and drops in_ready.
    write_hold(16'($urandom_range(2, 40)));
    hold_off_req = LONG_STALL;
    random_traffic(base + 300);

    // Sender pauses until every change is out, then carries on.
    wait_idle();
    write_hold(16'd16);
    random_traffic(base + RANDOM_ITEMS);
    wait_idle();

    $display("ran %0d commands and samples over several hold settings", items_sent);
    $display("checked %0d line changes: %0d reads returned, %0d misuse flags",
             board.changes_checked, board.reads_done, board.misuse_seen);
    if (board.fail_count == 0 && board.expected_changes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/i2cmls_pkg.sv
design/i2c_master_line_sequencer_top.sv
tb/sv/tb.sv
